// ===== src/rrtt_pkg.sv =====
package rrtt_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam logic [3:0] MAX_RETRIES_RESET = 4'd4;
    localparam logic [23:0] INITIAL_TIMEOUT_RESET = 24'd1000000;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RECV = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [2:0] PDU_GET = 3'd0;
    localparam logic [2:0] PDU_GETNEXT = 3'd1;
    localparam logic [2:0] PDU_RESPONSE = 3'd2;
    localparam logic [2:0] PDU_SET = 3'd3;
    localparam logic [2:0] PDU_TRAP = 3'd4;

    localparam logic [2:0] KIND_SENT = 3'd0;
    localparam logic [2:0] KIND_FULL = 3'd1;
    localparam logic [2:0] KIND_MATCHED = 3'd2;
    localparam logic [2:0] KIND_INCOMING = 3'd3;
    localparam logic [2:0] KIND_RETRANSMIT = 3'd4;
    localparam logic [2:0] KIND_TIMEOUT = 3'd5;

    localparam logic CFG_MAX_RETRIES = 1'b0;
    localparam logic CFG_INITIAL_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND,
        ST_RECV,
        ST_TICK,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic do_send;   // allocate / assign id
        logic do_recv;   // match response or report incoming
        logic do_tick;   // advance time
        logic visit;     // process slot at scan index
        logic scan_inc;  // advance scan index
        logic scan_clr;
        logic res_take;  // output register consumed
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_end;  // scan index on last slot
        logic res_full;  // output register occupied
    } status_t;

endpackage

// ===== src/request_retry_timeout_table.sv =====
// Outstanding-request table with exponential-backoff retransmission for one session.
// An input transfer is taken only while no result is waiting on the output. A send,
// or a receive that gives a result, first loads the input item into the item registers
// and then writes its result into the output register. A tick advances time, visits
// every slot in slot order, and then closes the scan; a slot visit waits while the
// single result register is still held by the sink. A tick result carries tlast when
// no later slot has expired. Configuration writes are taken at any time and must
// happen only while no item is in flight.
module request_retry_timeout_table #(
    parameter int DEPTH = rrtt_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // op[1:0], pdu_type[4:2], handle[20:5], rx_request_id[52:21]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // kind[2:0], req_id[34:3], tag[50:35], attempt[54:51]
    output logic        m_tlast
);

    logic [3:0]  max_retries_reg;
    logic [23:0] init_to_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_retries_reg <= rrtt_pkg::MAX_RETRIES_RESET;
            init_to_reg <= rrtt_pkg::INITIAL_TIMEOUT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == rrtt_pkg::CFG_MAX_RETRIES)
                max_retries_reg <= cfg_data[3:0];
            else
                init_to_reg <= cfg_data;
        end
    end

    rrtt_pkg::cmd_t    cmd;
    rrtt_pkg::status_t status;
    logic [2:0]  r_kind;
    logic [31:0] r_id;
    logic [15:0] r_tag;
    logic [3:0]  r_att;
    logic        r_last;
    logic        in_ready;
    logic        out_fire;

    assign out_fire = m_tvalid && m_tready;
    assign s_tready = in_ready;

    rrtt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_tvalid && s_tready), .in_op(s_tdata[1:0]),
        .out_fire(out_fire),
        .status(status), .cmd(cmd), .in_ready(in_ready)
    );

    rrtt_datapath #(.DEPTH(DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .in_pdu(s_tdata[4:2]), .in_handle(s_tdata[20:5]),
        .in_rxid(s_tdata[52:21]),
        .max_retries(max_retries_reg), .initial_timeout(init_to_reg),
        .res_kind(r_kind), .res_id(r_id), .res_tag(r_tag), .res_attempt(r_att),
        .res_last(r_last)
    );

    // present the datapath result register directly
    assign m_tvalid = status.res_full;
    assign m_tdata = {1'b0, r_att, r_tag, r_id, r_kind};
    assign m_tlast = r_last;

endmodule

// ===== src/rrtt_datapath.sv =====
module rrtt_datapath #(
    parameter int DEPTH = rrtt_pkg::DEPTH_DEFAULT,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rrtt_pkg::cmd_t      cmd,
    output rrtt_pkg::status_t   status,
    input  logic [2:0]          in_pdu,
    input  logic [15:0]         in_handle,
    input  logic [31:0]         in_rxid,
    input  logic [3:0]          max_retries,
    input  logic [23:0]         initial_timeout,
    output logic [2:0]          res_kind,
    output logic [31:0]         res_id,
    output logic [15:0]         res_tag,
    output logic [3:0]          res_attempt,
    output logic                res_last
);

    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [31:0] id_reg [DEPTH];
    logic [15:0] tag_reg [DEPTH];
    logic [3:0]  att_reg [DEPTH];
    logic [31:0] wait_reg [DEPTH];
    logic [39:0] dl_reg [DEPTH];
    logic [39:0] now_reg;
    logic [31:0] idc_reg;
    logic [IW-1:0] scan_reg;
    logic [2:0] pdu_reg;
    logic [15:0] handle_reg;
    logic [31:0] rxid_reg;
    logic full_reg;

    // lowest free slot and lowest matching slot
    logic free_found, match_found;
    logic [IW-1:0] free_idx, match_idx;
    always_comb begin
        free_found = 1'b0;
        free_idx = '0;
        match_found = 1'b0;
        match_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx = IW'(i);
            end
            if (valid_reg[i] && id_reg[i] == rxid_reg) begin
                match_found = 1'b1;
                match_idx = IW'(i);
            end
        end
    end

    logic is_req;
    assign is_req = (pdu_reg == rrtt_pkg::PDU_GET) || (pdu_reg == rrtt_pkg::PDU_GETNEXT)
                 || (pdu_reg == rrtt_pkg::PDU_SET);

    // expiry of every slot against the current time
    logic [39:0] diff [DEPTH];
    logic [DEPTH-1:0] exp_vec;
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            diff[i] = dl_reg[i] - now_reg;
            exp_vec[i] = valid_reg[i] && diff[i][39];
        end
    end

    logic expired;
    logic give_up;
    logic more_after;
    logic [31:0] wait_dbl;
    logic [3:0] att_inc;
    assign expired = exp_vec[scan_reg];
    assign give_up = att_reg[scan_reg] >= max_retries;
    assign wait_dbl = wait_reg[scan_reg][31] ? 32'hFFFF_FFFF : {wait_reg[scan_reg][30:0], 1'b0};
    assign att_inc = att_reg[scan_reg] + 4'd1;

    // a tick result is last when no later slot has expired
    rrtt_lastfix #(.DEPTH(DEPTH)) u_last (
        .exp_vec(exp_vec), .scan_idx(scan_reg), .more_after(more_after)
    );

    logic [31:0] idc_inc;
    assign idc_inc = idc_reg + 32'd1;

    assign status.scan_end = (scan_reg == IW'(DEPTH - 1));
    assign status.res_full = full_reg;

    // valid bits, time, id counter, scan index, result flag
    always_comb begin
        valid_next = valid_reg;
        if (cmd.do_send && is_req && free_found)
            valid_next[free_idx] = 1'b1;
        if (cmd.do_recv && pdu_reg == rrtt_pkg::PDU_RESPONSE && match_found)
            valid_next[match_idx] = 1'b0;
        if (cmd.visit && expired && give_up)
            valid_next[scan_reg] = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            now_reg <= '0;
            idc_reg <= '0;
            scan_reg <= '0;
            full_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cmd.do_tick)
                now_reg <= now_reg + 40'd1;
            if (cmd.do_send && (is_req || pdu_reg == rrtt_pkg::PDU_RESPONSE))
                idc_reg <= idc_inc;
            if (cmd.scan_clr)
                scan_reg <= '0;
            else if (cmd.scan_inc)
                scan_reg <= scan_reg + IW'(1);
            if (cmd.do_send || (cmd.do_recv && (pdu_reg == rrtt_pkg::PDU_RESPONSE
                    ? match_found
                    : (is_req || pdu_reg == rrtt_pkg::PDU_TRAP)))
                    || (cmd.visit && expired))
                full_reg <= 1'b1;
            else if (cmd.res_take)
                full_reg <= 1'b0;
        end
    end

    // slot payload and result register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pdu_reg <= in_pdu;
            handle_reg <= in_handle;
            rxid_reg <= in_rxid;
        end
        if (cmd.do_send) begin
            res_kind <= (is_req && !free_found) ? rrtt_pkg::KIND_FULL : rrtt_pkg::KIND_SENT;
            res_id <= (is_req || pdu_reg == rrtt_pkg::PDU_RESPONSE) ? idc_inc : 32'd0;
            res_tag <= handle_reg;
            res_attempt <= (is_req && free_found) ? 4'd1 : 4'd0;
            res_last <= 1'b1;
            if (is_req && free_found) begin
                id_reg[free_idx] <= idc_inc;
                tag_reg[free_idx] <= handle_reg;
                att_reg[free_idx] <= 4'd1;
                wait_reg[free_idx] <= {8'd0, initial_timeout};
                dl_reg[free_idx] <= now_reg + {16'd0, initial_timeout};
            end
        end else if (cmd.do_recv) begin
            res_id <= rxid_reg;
            res_last <= 1'b1;
            if (pdu_reg == rrtt_pkg::PDU_RESPONSE) begin
                res_kind <= rrtt_pkg::KIND_MATCHED;
                res_tag <= tag_reg[match_idx];
                res_attempt <= att_reg[match_idx];
            end else begin
                res_kind <= rrtt_pkg::KIND_INCOMING;
                res_tag <= 16'd0;
                res_attempt <= 4'd0;
            end
        end else if (cmd.visit && expired) begin
            res_id <= id_reg[scan_reg];
            res_tag <= tag_reg[scan_reg];
            res_last <= !more_after;
            if (give_up) begin
                res_kind <= rrtt_pkg::KIND_TIMEOUT;
                res_attempt <= att_reg[scan_reg];
            end else begin
                res_kind <= rrtt_pkg::KIND_RETRANSMIT;
                res_attempt <= att_inc;
                att_reg[scan_reg] <= att_inc;
                wait_reg[scan_reg] <= wait_dbl;
                dl_reg[scan_reg] <= now_reg + {8'd0, wait_dbl};
            end
        end
    end

endmodule

// ===== src/rrtt_ctrl.sv =====
module rrtt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic [1:0]         in_op,
    input  logic               out_fire,
    input  rrtt_pkg::status_t  status,
    output rrtt_pkg::cmd_t     cmd,
    output logic               in_ready
);

    rrtt_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrtt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequence: load, operate, then wait for each result to drain
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.res_take = out_fire;
        in_ready = 1'b0;
        case (state_reg)
            rrtt_pkg::ST_IDLE: begin
                in_ready = !status.res_full;
                if (in_fire) begin
                    cmd.load = 1'b1;
                    case (in_op)
                        rrtt_pkg::OP_SEND: state_next = rrtt_pkg::ST_SEND;
                        rrtt_pkg::OP_RECV: state_next = rrtt_pkg::ST_RECV;
                        rrtt_pkg::OP_TICK: begin
                            cmd.do_tick = 1'b1;
                            cmd.scan_clr = 1'b1;
                            state_next = rrtt_pkg::ST_TICK;
                        end
                        default: state_next = rrtt_pkg::ST_IDLE;
                    endcase
                end
            end
            rrtt_pkg::ST_SEND: begin
                cmd.do_send = 1'b1;
                state_next = rrtt_pkg::ST_IDLE;
            end
            rrtt_pkg::ST_RECV: begin
                cmd.do_recv = 1'b1;
                state_next = rrtt_pkg::ST_IDLE;
            end
            rrtt_pkg::ST_TICK: begin
                // visit one slot when the output register is free
                if (!status.res_full || out_fire) begin
                    cmd.visit = 1'b1;
                    cmd.scan_inc = 1'b1;
                    if (status.scan_end)
                        state_next = rrtt_pkg::ST_OUT;
                end
            end
            rrtt_pkg::ST_OUT: begin
                // close the scan; the next item waits for the last result
                state_next = rrtt_pkg::ST_IDLE;
            end
            default: state_next = rrtt_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== src/rrtt_lastfix.sv =====
module rrtt_lastfix #(
    parameter int DEPTH = rrtt_pkg::DEPTH_DEFAULT,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic [DEPTH-1:0] exp_vec,
    input  logic [IW-1:0]    scan_idx,
    output logic             more_after
);

    // flag any expired slot above the one being visited
    always_comb begin
        more_after = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (exp_vec[i] && (IW'(i) > scan_idx))
                more_after = 1'b1;
        end
    end

endmodule
